[rtl/tda_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tda_pkg
// Types and constants shared by the time-of-day arithmetic pipeline.
// ----------------------------------------------------------------------------
package tda_pkg;

  localparam logic [16:0] DAY_SECONDS    = 17'd86400;
  localparam logic [16:0] HOUR_SECONDS   = 17'd3600;
  localparam logic [16:0] MINUTE_SECONDS = 17'd60;
  localparam logic [4:0]  MAX_HOUR       = 5'd23;
  localparam logic [5:0]  MAX_MINUTE     = 6'd59;

  // floor(2^32 / 675); offset[30:7] times this, high bits, gives offset / 86400 or one less
  localparam logic [22:0] DAY_RECIP      = 23'd6362914;
  // ceil(2^20 / 225); exact hour from seconds[16:4]
  localparam logic [12:0] HOUR_RECIP     = 13'd4661;
  // ceil(2^14 / 15); exact minute from remainder[11:2]
  localparam logic [10:0] MINUTE_RECIP   = 11'd1093;

  typedef struct packed {
    logic        op;
    logic [4:0]  hour_a;
    logic [5:0]  minute_a;
    logic [5:0]  second_a;
    logic [4:0]  hour_b;
    logic [5:0]  minute_b;
    logic [5:0]  second_b;
    logic [30:0] offset_seconds;
  } tda_in_t;

  typedef struct packed {
    logic [4:0]  hour_r;
    logic [5:0]  minute_r;
    logic [5:0]  second_r;
    logic [16:0] duration;
    logic        is_equal;
    logic        is_before;
    logic        is_after;
    logic        a_valid;
  } tda_out_t;

  // results fixed in the first stage and carried along
  typedef struct packed {
    logic [16:0] duration;
    logic        is_equal;
    logic        is_before;
    logic        is_after;
    logic        a_valid;
  } tda_cmp_t;

endpackage
`default_nettype wire

[rtl/tda_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tda_front
// Stages 1-2: seconds of A and B, compare flags, duration, offset mod 86400.
// ----------------------------------------------------------------------------
module tda_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire logic              in_v,
  input  wire tda_pkg::tda_in_t  in_d,
  output logic                   out_v,
  output logic                   out_op,
  output logic [16:0]            out_sa,
  output logic [16:0]            out_nmod,
  output tda_pkg::tda_cmp_t      out_cmp
);

  logic [16:0]       sa, sb;
  logic [17:0]       diff;
  logic [46:0]       prod;
  tda_pkg::tda_cmp_t cmp;

  logic              s1_v_r;
  logic              s1_op_r;
  logic [16:0]       s1_sa_r;
  logic [30:0]       s1_n_r;
  logic [14:0]       s1_q_r;
  tda_pkg::tda_cmp_t s1_cmp_r;

  logic [31:0]       qm;
  logic [17:0]       rem;
  logic [16:0]       nmod_nxt;

  logic              s2_v_r;
  logic              s2_op_r;
  logic [16:0]       s2_sa_r;
  logic [16:0]       s2_nmod_r;
  tda_pkg::tda_cmp_t s2_cmp_r;

  always_comb begin
    sa = 17'(in_d.hour_a) * tda_pkg::HOUR_SECONDS
       + 17'(in_d.minute_a) * tda_pkg::MINUTE_SECONDS
       + 17'(in_d.second_a);
    sb = 17'(in_d.hour_b) * tda_pkg::HOUR_SECONDS
       + 17'(in_d.minute_b) * tda_pkg::MINUTE_SECONDS
       + 17'(in_d.second_b);
    diff = {1'b0, sb} - {1'b0, sa};
    cmp.duration  = (sb >= sa) ? diff[16:0] : (diff[16:0] + tda_pkg::DAY_SECONDS);
    cmp.is_equal  = (in_d.hour_a == in_d.hour_b) && (in_d.minute_a == in_d.minute_b)
                    && (in_d.second_a == in_d.second_b);
    cmp.is_before = (sa < sb);
    cmp.is_after  = (sa > sb);
    cmp.a_valid   = (in_d.hour_a <= tda_pkg::MAX_HOUR)
                    && (in_d.minute_a <= tda_pkg::MAX_MINUTE)
                    && (in_d.second_a <= tda_pkg::MAX_MINUTE);
    prod = 47'(in_d.offset_seconds[30:7]) * 47'(tda_pkg::DAY_RECIP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r  <= in_d.op;
      s1_sa_r  <= sa;
      s1_n_r   <= in_d.offset_seconds;
      s1_q_r   <= prod[46:32];
      s1_cmp_r <= cmp;
    end
  end

  // quotient estimate is exact or one low, so one correction step
  always_comb begin
    qm       = 32'(s1_q_r) * 32'(tda_pkg::DAY_SECONDS);
    rem      = 18'(32'(s1_n_r) - qm);
    nmod_nxt = (rem >= 18'(tda_pkg::DAY_SECONDS)) ?
               17'(rem - 18'(tda_pkg::DAY_SECONDS)) : rem[16:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_op_r   <= s1_op_r;
      s2_sa_r   <= s1_sa_r;
      s2_nmod_r <= nmod_nxt;
      s2_cmp_r  <= s1_cmp_r;
    end
  end

  assign out_v    = s2_v_r;
  assign out_op   = s2_op_r;
  assign out_sa   = s2_sa_r;
  assign out_nmod = s2_nmod_r;
  assign out_cmp  = s2_cmp_r;

endmodule
`default_nettype wire

[rtl/tda_shift.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tda_shift
// Stage 3: shift A by the reduced offset and wrap into one day.
// ----------------------------------------------------------------------------
module tda_shift (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire logic              in_v,
  input  wire logic              in_op,
  input  wire logic [16:0]       in_sa,
  input  wire logic [16:0]       in_nmod,
  input  wire tda_pkg::tda_cmp_t in_cmp,
  output logic                   out_v,
  output logic [16:0]            out_secs,
  output tda_pkg::tda_cmp_t      out_cmp
);

  logic [17:0]       t;
  logic [16:0]       secs_nxt;

  logic              v_r;
  logic [16:0]       secs_r;
  tda_pkg::tda_cmp_t cmp_r;

  // t stays below three days, even for out-of-range A
  always_comb begin
    if (in_op) begin
      t = {1'b0, in_sa} + 18'(tda_pkg::DAY_SECONDS) - {1'b0, in_nmod};
    end else begin
      t = {1'b0, in_sa} + {1'b0, in_nmod};
    end
    if (t >= 18'(2 * 86400)) begin
      secs_nxt = 17'(t - 18'(2 * 86400));
    end else if (t >= 18'(tda_pkg::DAY_SECONDS)) begin
      secs_nxt = 17'(t - 18'(tda_pkg::DAY_SECONDS));
    end else begin
      secs_nxt = t[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      secs_r <= secs_nxt;
      cmp_r  <= in_cmp;
    end
  end

  assign out_v    = v_r;
  assign out_secs = secs_r;
  assign out_cmp  = cmp_r;

endmodule
`default_nettype wire

[rtl/tda_split.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tda_split
// Stages 4-6: split seconds of day into hour, minute and leftover seconds.
// ----------------------------------------------------------------------------
module tda_split (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire logic              in_v,
  input  wire logic [16:0]       in_secs,
  input  wire tda_pkg::tda_cmp_t in_cmp,
  output logic                   out_v,
  output logic [4:0]             out_hour,
  output logic [5:0]             out_minute,
  output logic [11:0]            out_rem,
  output tda_pkg::tda_cmp_t      out_cmp
);

  logic [25:0]       hprod;
  logic [16:0]       hsub;
  logic [20:0]       mprod;

  logic              s4_v_r;
  logic [16:0]       s4_secs_r;
  logic [4:0]        s4_hour_r;
  tda_pkg::tda_cmp_t s4_cmp_r;

  logic              s5_v_r;
  logic [4:0]        s5_hour_r;
  logic [11:0]       s5_rem_r;
  tda_pkg::tda_cmp_t s5_cmp_r;

  logic              s6_v_r;
  logic [4:0]        s6_hour_r;
  logic [5:0]        s6_minute_r;
  logic [11:0]       s6_rem_r;
  tda_pkg::tda_cmp_t s6_cmp_r;

  always_comb begin
    hprod = 26'(in_secs[16:4]) * 26'(tda_pkg::HOUR_RECIP);
    hsub  = s4_secs_r - 17'(s4_hour_r) * tda_pkg::HOUR_SECONDS;
    mprod = 21'(s5_rem_r[11:2]) * 21'(tda_pkg::MINUTE_RECIP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
    end else if (adv) begin
      s4_v_r <= in_v;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_secs_r   <= in_secs;
      s4_hour_r   <= hprod[24:20];
      s4_cmp_r    <= in_cmp;
      s5_hour_r   <= s4_hour_r;
      s5_rem_r    <= hsub[11:0];
      s5_cmp_r    <= s4_cmp_r;
      s6_hour_r   <= s5_hour_r;
      s6_minute_r <= mprod[19:14];
      s6_rem_r    <= s5_rem_r;
      s6_cmp_r    <= s5_cmp_r;
    end
  end

  assign out_v      = s6_v_r;
  assign out_hour   = s6_hour_r;
  assign out_minute = s6_minute_r;
  assign out_rem    = s6_rem_r;
  assign out_cmp    = s6_cmp_r;

endmodule
`default_nettype wire

[rtl/time_of_day_arithmetic.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// time_of_day_arithmetic
// Adds or subtracts a seconds offset to a time of day and compares two times.
// ----------------------------------------------------------------------------
// One transaction in, one transaction out. The block takes a transaction every
// cycle while not stalled and returns its result through the seven register
// stages (seconds conversion with offset reciprocal multiply, offset
// remainder, day wrap, hour, hour remainder, minute, output register). While
// out_stall holds back a waiting result the whole pipeline freezes and
// in_stall is raised. Out-of-range fields of A and B are accepted and go
// through the same arithmetic. No state is kept between transactions.
module time_of_day_arithmetic (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire tda_pkg::tda_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output tda_pkg::tda_out_t      out_data
);

  logic              adv;

  logic              f_v;
  logic              f_op;
  logic [16:0]       f_sa;
  logic [16:0]       f_nmod;
  tda_pkg::tda_cmp_t f_cmp;

  logic              h_v;
  logic [16:0]       h_secs;
  tda_pkg::tda_cmp_t h_cmp;

  logic              p_v;
  logic [4:0]        p_hour;
  logic [5:0]        p_minute;
  logic [11:0]       p_rem;
  tda_pkg::tda_cmp_t p_cmp;

  logic [11:0]       sec_full;
  tda_pkg::tda_out_t out_nxt;

  logic              out_valid_r;
  tda_pkg::tda_out_t out_data_r;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  tda_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (in_valid),
    .in_d     (in_data),
    .out_v    (f_v),
    .out_op   (f_op),
    .out_sa   (f_sa),
    .out_nmod (f_nmod),
    .out_cmp  (f_cmp)
  );

  tda_shift u_shift (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (f_v),
    .in_op    (f_op),
    .in_sa    (f_sa),
    .in_nmod  (f_nmod),
    .in_cmp   (f_cmp),
    .out_v    (h_v),
    .out_secs (h_secs),
    .out_cmp  (h_cmp)
  );

  tda_split u_split (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_v       (h_v),
    .in_secs    (h_secs),
    .in_cmp     (h_cmp),
    .out_v      (p_v),
    .out_hour   (p_hour),
    .out_minute (p_minute),
    .out_rem    (p_rem),
    .out_cmp    (p_cmp)
  );

  always_comb begin
    sec_full           = p_rem - 12'(p_minute) * 12'(tda_pkg::MINUTE_SECONDS);
    out_nxt.hour_r     = p_hour;
    out_nxt.minute_r   = p_minute;
    out_nxt.second_r   = sec_full[5:0];
    out_nxt.duration   = p_cmp.duration;
    out_nxt.is_equal   = p_cmp.is_equal;
    out_nxt.is_before  = p_cmp.is_before;
    out_nxt.is_after   = p_cmp.is_after;
    out_nxt.a_valid    = p_cmp.a_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= p_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

[tb/sv/time_of_day_arithmetic_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_of_day_arithmetic_test
// Drives time-of-day transactions into the shift/compare pipeline and checks
// every result field against a cycle-free predictor of the same arithmetic.
// Directed corner cases come first, then three random phases with random
// gaps on both channels, a long output hold-off and a full drain between
// phases.
// ----------------------------------------------------------------------------
module time_of_day_arithmetic_test;

  localparam logic   OP_ADD       = 1'b0;
  localparam logic   OP_SUB       = 1'b1;
  localparam longint DAY          = 86400;
  localparam longint HOUR         = 3600;
  localparam longint MINUTE       = 60;
  localparam int     MAX_WAIT     = 12;
  localparam int     LONG_HOLD    = 300;
  localparam int     DRAIN_CYCLES = 20;
  localparam int     CYCLE_LIMIT  = 400000;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  tda_pkg::tda_in_t   in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  tda_pkg::tda_out_t  out_data;

  tda_pkg::tda_in_t   pending_items[$];
  tda_pkg::tda_out_t  expected_results[$];
  tda_pkg::tda_out_t  want;
  logic     in_taken      = 1'b0;
  logic     out_taken     = 1'b0;
  int       gap_left      = 0;
  int       out_wait      = 0;
  bit       send_quiet    = 1'b0;
  bit       recv_quiet    = 1'b0;
  bit       long_hold_req = 1'b0;
  int       error_count   = 0;
  int       cycle_count   = 0;

  time_of_day_arithmetic uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic tda_pkg::tda_out_t shift_and_compare(input tda_pkg::tda_in_t t);
    longint sec_a, sec_b, shifted, rem, dur;
    tda_pkg::tda_out_t r;
    sec_a = HOUR * longint'(t.hour_a) + MINUTE * longint'(t.minute_a) + longint'(t.second_a);
    sec_b = HOUR * longint'(t.hour_b) + MINUTE * longint'(t.minute_b) + longint'(t.second_b);
    if (t.op == OP_ADD) begin
      shifted = (sec_a + longint'(t.offset_seconds)) % DAY;
    end else begin
      shifted = (sec_a + DAY - (longint'(t.offset_seconds) % DAY)) % DAY;
    end
    if (sec_b >= sec_a) begin
      dur = sec_b - sec_a;
    end else begin
      dur = DAY - (sec_a - sec_b);
    end
    rem = shifted % HOUR;
    r.hour_r    = 5'(shifted / HOUR);
    r.minute_r  = 6'(rem / MINUTE);
    r.second_r  = 6'(rem % MINUTE);
    r.duration  = dur[16:0];
    r.is_equal  = (t.hour_a == t.hour_b) && (t.minute_a == t.minute_b) &&
                  (t.second_a == t.second_b);
    r.is_before = sec_a < sec_b;
    r.is_after  = sec_a > sec_b;
    r.a_valid   = (t.hour_a <= 23) && (t.minute_a <= 59) && (t.second_a <= 59);
    return r;
  endfunction

  task automatic check_field(input string field, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", field, exp_v, act_v);
      error_count++;
    end
  endtask

  task automatic push_item(input logic op, input int ha, input int ma, input int sa,
                           input int hb, input int mb, input int sb, input longint n);
    tda_pkg::tda_in_t t;
    t.op             = op;
    t.hour_a         = 5'(ha);
    t.minute_a       = 6'(ma);
    t.second_a       = 6'(sa);
    t.hour_b         = 5'(hb);
    t.minute_b       = 6'(mb);
    t.second_b       = 6'(sb);
    t.offset_seconds = 31'(n);
    pending_items.push_back(t);
  endtask

  task automatic push_random(input int count);
    tda_pkg::tda_in_t t;
    int kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 9);
      t.op = 1'($urandom_range(0, 1));
      if (kind < 6) begin
        t.hour_a   = 5'($urandom_range(0, 23));
        t.minute_a = 6'($urandom_range(0, 59));
        t.second_a = 6'($urandom_range(0, 59));
        t.hour_b   = 5'($urandom_range(0, 23));
        t.minute_b = 6'($urandom_range(0, 59));
        t.second_b = 6'($urandom_range(0, 59));
      end else begin
        t.hour_a   = 5'($urandom());
        t.minute_a = 6'($urandom());
        t.second_a = 6'($urandom());
        t.hour_b   = 5'($urandom());
        t.minute_b = 6'($urandom());
        t.second_b = 6'($urandom());
      end
      if ($urandom_range(0, 7) == 0) begin
        t.hour_b   = t.hour_a;
        t.minute_b = t.minute_a;
        t.second_b = t.second_a;
      end
      case ($urandom_range(0, 3))
        0: t.offset_seconds = 31'($urandom_range(0, 86399));
        1: t.offset_seconds = 31'($urandom());
        2: t.offset_seconds = 31'(DAY * $urandom_range(0, 24854) + $urandom_range(0, 2));
        default: t.offset_seconds = 31'($urandom_range(0, 200));
      endcase
      pending_items.push_back(t);
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_taken)) begin
      if (in_valid) begin
        if ($urandom_range(0, 49) == 0) send_quiet = !send_quiet;
        gap_left = send_quiet ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pending_items.size() != 0) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (long_hold_req) begin
        out_wait      = LONG_HOLD;
        long_hold_req = 1'b0;
      end else if (out_taken) begin
        if ($urandom_range(0, 49) == 0) recv_quiet = !recv_quiet;
        out_wait = recv_quiet ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (out_wait > 0) begin
        out_stall <= 1'b1;
        out_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    in_taken  <= rst_n && in_valid && !in_stall;
    out_taken <= rst_n && out_valid && !out_stall;
    if (rst_n && in_valid && !in_stall) begin
      expected_results.push_back(shift_and_compare(in_data));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with no input transaction pending");
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("hour_r", longint'(want.hour_r), longint'(out_data.hour_r));
        check_field("minute_r", longint'(want.minute_r), longint'(out_data.minute_r));
        check_field("second_r", longint'(want.second_r), longint'(out_data.second_r));
        check_field("duration", longint'(want.duration), longint'(out_data.duration));
        check_field("is_equal", longint'(want.is_equal), longint'(out_data.is_equal));
        check_field("is_before", longint'(want.is_before), longint'(out_data.is_before));
        check_field("is_after", longint'(want.is_after), longint'(out_data.is_after));
        check_field("a_valid", longint'(want.a_valid), longint'(out_data.a_valid));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    // directed corners
    push_item(OP_ADD, 0, 0, 0, 0, 0, 0, 0);
    push_item(OP_ADD, 23, 59, 59, 0, 0, 0, 1);
    push_item(OP_SUB, 0, 0, 0, 23, 59, 59, 1);
    push_item(OP_ADD, 12, 30, 15, 6, 0, 0, 2147483647);
    push_item(OP_SUB, 12, 30, 15, 18, 0, 0, 2147483647);
    push_item(OP_SUB, 5, 6, 7, 5, 6, 8, 86400);
    push_item(OP_ADD, 5, 6, 7, 5, 6, 6, 86400);
    push_item(OP_ADD, 1, 2, 3, 4, 5, 6, 86399);
    push_item(OP_SUB, 1, 2, 3, 4, 5, 6, 86401);
    push_item(OP_ADD, 31, 63, 63, 0, 0, 0, 0);
    push_item(OP_SUB, 31, 63, 63, 0, 0, 0, 1000);
    push_item(OP_ADD, 0, 0, 0, 31, 63, 63, 5);
    push_item(OP_SUB, 31, 63, 63, 31, 63, 63, 2147483647);
    push_item(OP_ADD, 1, 0, 0, 0, 60, 0, 0);
    push_item(OP_SUB, 0, 1, 0, 0, 0, 60, 60);
    push_item(OP_ADD, 24, 0, 0, 23, 59, 59, 3);
    push_item(OP_ADD, 0, 60, 0, 0, 59, 0, 7);
    push_item(OP_SUB, 0, 0, 60, 0, 0, 59, 7);
    push_item(OP_ADD, 23, 59, 59, 23, 59, 59, 0);
    push_item(OP_SUB, 10, 0, 0, 9, 59, 59, 36000);
    push_item(OP_ADD, 9, 59, 59, 10, 0, 0, 50400);
    push_item(OP_SUB, 30, 0, 0, 2, 0, 0, 0);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_random(400);
    // sender holds back until everything is back
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    push_random(400);
    long_hold_req = 1'b1;
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    push_random(350);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
